### hw/rtl/rpra_pkg.sv
// shared constants, types and tables of the rotating point ring animator
package rpra_pkg;

    localparam int MAX_POINTS = 8;
    localparam int CORDIC_STAGES = 14;

    localparam logic signed [15:0] PHASE_PI = 16'sd25736;
    localparam logic signed [17:0] RAD_TO_BIN = 18'sd83443;
    localparam logic signed [26:0] CORDIC_GAIN = 27'sd10188012;
    localparam logic signed [16:0] Q14_ONE = 17'sd16384;

    localparam logic [2:0] REG_POINT_COUNT = 3'd0;
    localparam logic [2:0] REG_BEAT_RESTART = 3'd1;
    localparam logic [2:0] REG_ROT_STEP_START = 3'd2;
    localparam logic [2:0] REG_ROT_STEP_END = 3'd3;
    localparam logic [2:0] REG_ALPHA_PAIR = 3'd4;
    localparam logic [2:0] REG_DISTANCE_START = 3'd5;
    localparam logic [2:0] REG_DISTANCE_END = 3'd6;
    localparam logic [2:0] REG_PHASE_SPEED = 3'd7;

    typedef struct packed {
        logic done;
        logic signed [15:0] cos_q14;
        logic signed [15:0] sin_q14;
    } trig_t;

    // binary angle of atan(2^-i), 65536 per turn
    function automatic logic signed [17:0] cordic_atan(input logic [3:0] idx);
        logic signed [17:0] r;
        case (idx)
            4'd0: r = 18'sd8192;
            4'd1: r = 18'sd4836;
            4'd2: r = 18'sd2555;
            4'd3: r = 18'sd1297;
            4'd4: r = 18'sd651;
            4'd5: r = 18'sd326;
            4'd6: r = 18'sd163;
            4'd7: r = 18'sd81;
            4'd8: r = 18'sd41;
            4'd9: r = 18'sd20;
            4'd10: r = 18'sd10;
            4'd11: r = 18'sd5;
            4'd12: r = 18'sd3;
            4'd13: r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    // 65536 / n, modulo one turn
    function automatic logic [15:0] point_spacing(input logic [3:0] n);
        logic [15:0] r;
        case (n)
            4'd2: r = 16'd32768;
            4'd3: r = 16'd21845;
            4'd4: r = 16'd16384;
            4'd5: r = 16'd13107;
            4'd6: r = 16'd10922;
            4'd7: r = 16'd9362;
            4'd8: r = 16'd8192;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/rpra_cordic.sv
// iterative cordic, binary angle in, q1.14 cosine and sine out
module rpra_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [15:0]       angle,
    output rpra_pkg::trig_t   res
);
    import rpra_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [3:0]        iter_reg, iter_next;
    logic              neg_reg, neg_next;
    logic signed [26:0] x_reg, x_next, y_reg, y_next;
    logic signed [17:0] a_reg, a_next;
    logic signed [17:0] a_in;
    logic signed [26:0] xs, ys;
    logic signed [16:0] xr, yr, xc, yc;

    always_comb
    begin
        a_in = 18'(signed'(angle));
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        neg_next = neg_reg;
        x_next = x_reg;
        y_next = y_reg;
        a_next = a_reg;
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = 4'd0;
            x_next = CORDIC_GAIN;
            y_next = 27'sd0;
            if (a_in > 18'sd16384)
            begin
                a_next = a_in - 18'sd32768;
                neg_next = 1'b1;
            end
            else if (a_in < -18'sd16384)
            begin
                a_next = a_in + 18'sd32768;
                neg_next = 1'b1;
            end
            else
            begin
                a_next = a_in;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (a_reg >= 18'sd0)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                a_next = a_reg - cordic_atan(iter_reg);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                a_next = a_reg + cordic_atan(iter_reg);
            end
            iter_next = iter_reg + 4'd1;
            if (iter_reg == 4'(CORDIC_STAGES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        a_reg <= a_next;
        neg_reg <= neg_next;
    end

    // round to q1.14 and clamp
    always_comb
    begin
        xr = 17'((x_reg + 27'sd512) >>> 10);
        yr = 17'((y_reg + 27'sd512) >>> 10);
        xc = (xr > Q14_ONE) ? Q14_ONE : ((xr < -Q14_ONE) ? -Q14_ONE : xr);
        yc = (yr > Q14_ONE) ? Q14_ONE : ((yr < -Q14_ONE) ? -Q14_ONE : yr);
        res.done = done_reg;
        res.cos_q14 = neg_reg ? 16'(-xc) : 16'(xc);
        res.sin_q14 = neg_reg ? 16'(-yc) : 16'(yc);
    end

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("cordic restarted while busy");
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("cordic done without finishing iterations");
    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> iter_reg < 4'(CORDIC_STAGES))
        else $error("cordic iteration count out of range");

endmodule

### hw/rtl/rotating_point_ring_animator.sv
// top level: config registers, frame sequencer, shared multiplier, output register
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  in       | in_valid / in_stall     | beat
//  out      | out_valid / out_stall   | offset_x, offset_y, blend_alpha, point_index,
//           |                         | last_point
//
//  a frame runs the cordic once for the phase sine and once for each point
//  in_stall is high from the accepted beat until the frame's last point is loaded
//  a stalled output holds the sequencer before the next point is loaded
//  reset puts rotation at zero and the phase at pi; cfg_ready is always high
module rotating_point_ring_animator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                beat,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  offset_x,
    output logic signed [15:0]  offset_y,
    output logic [7:0]          blend_alpha,
    output logic [2:0]          point_index,
    output logic                last_point
);
    import rpra_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BIN   = 4'd1;
    localparam logic [3:0] S_ANG   = 4'd2;
    localparam logic [3:0] S_WAIT1 = 4'd3;
    localparam logic [3:0] S_STEP  = 4'd4;
    localparam logic [3:0] S_ALPHA = 4'd5;
    localparam logic [3:0] S_RAD   = 4'd6;
    localparam logic [3:0] S_RLOAD = 4'd7;
    localparam logic [3:0] S_PWAIT = 4'd8;
    localparam logic [3:0] S_MX    = 4'd9;
    localparam logic [3:0] S_MY    = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]         point_count_reg;
    logic               beat_restart_reg;
    logic signed [6:0]  rot_step_start_reg, rot_step_end_reg;
    logic [15:0]        alpha_pair_reg;
    logic [6:0]         distance_start_reg, distance_end_reg;
    logic signed [15:0] phase_speed_reg;

    logic [3:0]         state_reg, state_next;
    logic signed [9:0]  rotation_reg, rotation_next;
    logic signed [15:0] phase_reg, phase_next;
    logic signed [41:0] prod_reg;
    logic signed [15:0] sn_reg, sn_next, cos_reg, cos_next, sin_reg, sin_next;
    logic signed [9:0]  step_reg, step_next;
    logic [7:0]         alpha_reg, alpha_next;
    logic signed [23:0] radius_reg, radius_next;
    logic [15:0]        ang_reg, ang_next;
    logic [2:0]         idx_reg, idx_next;
    logic signed [15:0] ox_reg, ox_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] offset_x_reg, offset_y_reg;
    logic [7:0]         blend_alpha_reg;
    logic [2:0]         point_index_reg;
    logic               last_point_reg;
    logic               out_load;

    logic signed [23:0] mul_a;
    logic signed [17:0] mul_b;
    logic [3:0]         n_eff;
    logic               is_last;
    logic               cordic_start;
    logic [15:0]        cordic_angle;
    trig_t              trig;

    logic signed [23:0] step_sum;
    logic signed [24:0] alpha_sum, alpha_clamp;
    logic [7:0]         rot_mag;
    logic [16:0]        start_q;
    logic [15:0]        start_angle;
    logic [15:0]        spacing;
    logic signed [10:0] rot_sum;
    logic signed [16:0] ph_sum;
    logic signed [15:0] offset_sat;

    function automatic logic signed [15:0] sat_offset(input logic signed [41:0] p);
        logic signed [21:0] v;
        v = 22'((p + 42'sd524288) >>> 20);
        if (v > 22'sd32767)
            return 16'sh7fff;
        else if (v < -22'sd32768)
            return 16'sh8000;
        else
            return 16'(v);
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign offset_x = offset_x_reg;
    assign offset_y = offset_y_reg;
    assign blend_alpha = blend_alpha_reg;
    assign point_index = point_index_reg;
    assign last_point = last_point_reg;

    assign n_eff = (point_count_reg > 4'(MAX_POINTS)) ? 4'(MAX_POINTS) : point_count_reg;
    assign is_last = ({1'b0, idx_reg} + 4'd1) == n_eff;
    assign spacing = point_spacing(n_eff);
    assign offset_sat = sat_offset(prod_reg);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= 4'd1;
            beat_restart_reg <= 1'b0;
            rot_step_start_reg <= 7'sd0;
            rot_step_end_reg <= 7'sd0;
            alpha_pair_reg <= 16'd0;
            distance_start_reg <= 7'd0;
            distance_end_reg <= 7'd0;
            phase_speed_reg <= 16'sd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POINT_COUNT: point_count_reg <= cfg_data[3:0];
                REG_BEAT_RESTART: beat_restart_reg <= cfg_data[0];
                REG_ROT_STEP_START: rot_step_start_reg <= signed'(cfg_data[6:0]);
                REG_ROT_STEP_END: rot_step_end_reg <= signed'(cfg_data[6:0]);
                REG_ALPHA_PAIR: alpha_pair_reg <= cfg_data;
                REG_DISTANCE_START: distance_start_reg <= cfg_data[6:0];
                REG_DISTANCE_END: distance_end_reg <= cfg_data[6:0];
                REG_PHASE_SPEED: phase_speed_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = 24'sd0;
        mul_b = 18'sd0;
        case (state_reg)
            S_BIN:
            begin
                mul_a = 24'(phase_reg);
                mul_b = RAD_TO_BIN;
            end
            S_STEP:
            begin
                mul_a = 24'(8'(rot_step_end_reg) - 8'(rot_step_start_reg));
                mul_b = 18'(sn_reg);
            end
            S_ALPHA:
            begin
                mul_a = 24'(signed'({1'b0, alpha_pair_reg[15:8]})
                            - signed'({1'b0, alpha_pair_reg[7:0]}));
                mul_b = 18'(sn_reg);
            end
            S_RAD:
            begin
                mul_a = 24'(signed'({1'b0, distance_end_reg})
                            - signed'({1'b0, distance_start_reg}));
                mul_b = 18'(sn_reg);
            end
            S_MX:
            begin
                mul_a = radius_reg;
                mul_b = 18'(cos_reg);
            end
            S_MY, S_OUT:
            begin
                mul_a = radius_reg;
                mul_b = 18'(sin_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 42'(mul_a) * 42'(mul_b);
    end

    // ring start angle, rotation * 65536 / 255 toward zero
    always_comb
    begin
        rot_mag = rotation_reg[9] ? 8'(-rotation_reg) : 8'(rotation_reg);
        start_q = {1'b0, rot_mag, 8'd0} + 17'(rot_mag) + 17'(rot_mag == 8'd255);
        start_angle = rotation_reg[9] ? 16'(-start_q) : 16'(start_q);
    end

    // frame sequencer
    always_comb
    begin
        state_next = state_reg;
        rotation_next = rotation_reg;
        phase_next = phase_reg;
        sn_next = sn_reg;
        cos_next = cos_reg;
        sin_next = sin_reg;
        step_next = step_reg;
        alpha_next = alpha_reg;
        radius_next = radius_reg;
        ang_next = ang_reg;
        idx_next = idx_reg;
        ox_next = ox_reg;
        cordic_start = 1'b0;
        cordic_angle = ang_reg;
        out_load = 1'b0;
        step_sum = 24'(rot_step_start_reg) * 24'sd16384 + 24'(prod_reg);
        alpha_sum = 25'(signed'({1'b0, alpha_pair_reg[7:0]})) * 25'sd16384
                    + 25'(prod_reg);
        alpha_clamp = (alpha_sum < 25'sd0) ? 25'sd0 :
                      ((alpha_sum > 25'sd4177920) ? 25'sd4177920 : alpha_sum);
        rot_sum = 11'(rotation_reg) + 11'(step_reg);
        ph_sum = 17'(phase_reg) + 17'(phase_speed_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && n_eff != 4'd0)
                begin
                    if (beat_restart_reg && beat && phase_reg >= PHASE_PI)
                        phase_next = 16'sd0;
                    state_next = S_BIN;
                end
            end
            S_BIN: state_next = S_ANG;
            S_ANG:
            begin
                cordic_start = 1'b1;
                cordic_angle = 16'((prod_reg + 42'sd32768) >>> 16);
                state_next = S_WAIT1;
            end
            S_WAIT1:
            begin
                if (trig.done)
                begin
                    sn_next = trig.sin_q14;
                    state_next = S_STEP;
                end
            end
            S_STEP: state_next = S_ALPHA;
            S_ALPHA:
            begin
                step_next = 10'(step_sum >>> 14)
                            + 10'(step_sum < 24'sd0 && step_sum[13:0] != 14'd0);
                state_next = S_RAD;
            end
            S_RAD:
            begin
                alpha_next = 8'((alpha_clamp + 25'sd8192) >>> 14);
                state_next = S_RLOAD;
            end
            S_RLOAD:
            begin
                radius_next = 24'(signed'({1'b0, distance_start_reg})) * 24'sd16384
                              + 24'(prod_reg);
                cordic_start = 1'b1;
                cordic_angle = start_angle;
                ang_next = start_angle;
                idx_next = 3'd0;
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (trig.done)
                begin
                    cos_next = trig.cos_q14;
                    sin_next = trig.sin_q14;
                    state_next = S_MX;
                end
            end
            S_MX: state_next = S_MY;
            S_MY:
            begin
                ox_next = offset_sat;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    if (is_last)
                    begin
                        if (rot_sum > 11'sd255)
                            rotation_next = 10'(rot_sum - 11'sd255);
                        else if (rot_sum < -11'sd255)
                            rotation_next = 10'(rot_sum + 11'sd255);
                        else
                            rotation_next = 10'(rot_sum);
                        if (ph_sum > 17'(PHASE_PI) || ph_sum < -17'(PHASE_PI))
                            phase_next = PHASE_PI;
                        else
                            phase_next = 16'(ph_sum);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cordic_start = 1'b1;
                        cordic_angle = ang_reg + spacing;
                        ang_next = ang_reg + spacing;
                        idx_next = idx_reg + 3'd1;
                        state_next = S_PWAIT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rotation_reg <= 10'sd0;
            phase_reg <= PHASE_PI;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rotation_reg <= rotation_next;
            phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sn_reg <= sn_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
        step_reg <= step_next;
        alpha_reg <= alpha_next;
        radius_reg <= radius_next;
        ang_reg <= ang_next;
        idx_reg <= idx_next;
        ox_reg <= ox_next;
        if (out_load)
        begin
            offset_x_reg <= ox_reg;
            offset_y_reg <= offset_sat;
            blend_alpha_reg <= alpha_reg;
            point_index_reg <= idx_reg;
            last_point_reg <= is_last;
        end
    end

    rpra_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (cordic_angle),
        .res   (trig)
    );

    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_PI && phase_reg >= -PHASE_PI)
        else $error("sweep phase out of range");
    a_rotation_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rotation_reg <= 10'sd255 && rotation_reg >= -10'sd255)
        else $error("ring rotation out of range");
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        trig.done |-> (state_reg == S_WAIT1 || state_reg == S_PWAIT))
        else $error("cordic result arrived outside a wait state");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && out_stall))
        else $error("output register overwritten while stalled");

endmodule

### sim/rotating_point_ring_animator_tb.sv
// testbench of the rotating point ring animator: directed table, then random frames
module rotating_point_ring_animator_tb;
    import rpra_pkg::*;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0] alpha;
        logic [2:0] idx;
        logic last;
    } point_t;

    typedef struct {
        bit wr;
        logic [2:0] idx;
        logic [15:0] data;
        bit b;
        bit typed;
        int ex;
        int ey;
        int ea;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic beat = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [7:0] blend_alpha;
    logic [2:0] point_index;
    logic last_point;

    rotating_point_ring_animator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .beat(beat),
        .out_valid(out_valid), .out_stall(out_stall),
        .offset_x(offset_x), .offset_y(offset_y), .blend_alpha(blend_alpha),
        .point_index(point_index), .last_point(last_point)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // ring state and register copies
    int n_points = 1;
    bit restart_en = 0;
    int step_lo = 0;
    int step_hi = 0;
    int alpha_bytes = 0;
    int radius_lo = 0;
    int radius_hi = 0;
    int speed = 0;
    int rotation = 0;
    int phase = 25736;

    point_t pending_points[$];
    int errors = 0;
    bit send_idle = 0;
    bit recv_stall = 0;
    int idle_pct = 59;
    bit hold_go = 0;
    bit hold_taken = 0;
    int hold_left = 0;
    int quiet = 0;

    const int ring_atan[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};

    function automatic int clip(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic angle_trig(input logic [15:0] ang, output int c, output int s);
        int a, x, y, t;
        bit flip;
        a = int'(signed'(ang));
        x = 10188012;
        y = 0;
        flip = 0;
        if (a > 16384)
        begin
            a -= 32768;
            flip = 1;
        end
        else if (a < -16384)
        begin
            a += 32768;
            flip = 1;
        end
        for (int i = 0; i < 14; i++)
        begin
            if (a >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                a -= ring_atan[i];
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                a += ring_atan[i];
            end
            x = t;
        end
        x = clip((x + 512) >>> 10, -16384, 16384);
        y = clip((y + 512) >>> 10, -16384, 16384);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic signed [15:0] to_q8(int trig, int radius);
        longint v;
        v = (longint'(trig) * radius + (longint'(1) << 19)) >>> 20;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic animate_frame(input bit b);
        int n, c, s, sn, cs, stp, a0, a1, al, radius, ph;
        longint bin;
        logic [15:0] base, spacing;
        point_t p;
        n = n_points > 8 ? 8 : n_points;
        if (n == 0) return;
        if (restart_en && b && phase >= 25736) phase = 0;
        bin = (longint'(phase) * 83443 + 32768) >>> 16;
        angle_trig(bin[15:0], cs, sn);
        stp = (step_lo * 16384 + (step_hi - step_lo) * sn) / 16384;
        a0 = alpha_bytes & 255;
        a1 = (alpha_bytes >> 8) & 255;
        al = clip(a0 * 16384 + (a1 - a0) * sn, 0, 255 * 16384);
        al = (al + 8192) >>> 14;
        radius = radius_lo * 16384 + (radius_hi - radius_lo) * sn;
        base = 16'((rotation * 65536) / 255);
        spacing = 16'(65536 / n);
        for (int i = 0; i < n; i++)
        begin
            angle_trig(base + 16'(i) * spacing, c, s);
            p.x = to_q8(c, radius);
            p.y = to_q8(s, radius);
            p.alpha = al[7:0];
            p.idx = i[2:0];
            p.last = (i + 1 == n);
            pending_points.push_back(p);
        end
        rotation += stp;
        if (rotation > 255) rotation -= 255;
        if (rotation < -255) rotation += 255;
        ph = phase + speed;
        if (ph > 25736) ph = 25736;
        if (ph < -25736) ph = 25736;
        phase = ph;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_POINT_COUNT: n_points = int'(data[3:0]);
            REG_BEAT_RESTART: restart_en = data[0];
            REG_ROT_STEP_START: step_lo = int'(signed'(data[6:0]));
            REG_ROT_STEP_END: step_hi = int'(signed'(data[6:0]));
            REG_ALPHA_PAIR: alpha_bytes = int'(data);
            REG_DISTANCE_START: radius_lo = int'(data[6:0]);
            REG_DISTANCE_END: radius_hi = int'(data[6:0]);
            default: speed = int'(signed'(data));
        endcase
    endtask

    task automatic send_frame(input bit b);
        while (send_idle && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        beat <= b;
        do @(posedge clk); while (in_stall);
        animate_frame(b);
    endtask

    task automatic drain();
        in_valid <= 0;
        cfg_valid <= 0;
        while (pending_points.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    row_t directed[] = '{
        '{0, REG_POINT_COUNT, 0, 0, 1, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 1, 1, 0, 0, 0},
        '{1, REG_ALPHA_PAIR, 16'h5A5A, 0, 0, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 1, 1, 0, 0, 90},
        '{1, REG_POINT_COUNT, 16'd8, 0, 0, 0, 0, 0},
        '{1, REG_DISTANCE_START, 16'd64, 0, 0, 0, 0, 0},
        '{1, REG_DISTANCE_END, 16'd64, 0, 0, 0, 0, 0},
        '{1, REG_ALPHA_PAIR, 16'hFF00, 0, 0, 0, 0, 0},
        '{1, REG_BEAT_RESTART, 16'd1, 0, 0, 0, 0, 0},
        '{1, REG_PHASE_SPEED, 16'd3217, 0, 0, 0, 0, 0},
        '{1, REG_ROT_STEP_START, 16'h0020, 0, 0, 0, 0, 0},
        '{1, REG_ROT_STEP_END, 16'h0060, 0, 0, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 1, 0, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 0, 0, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 0, 0, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 1, 0, 0, 0, 0},
        '{1, REG_POINT_COUNT, 16'd15, 0, 0, 0, 0, 0},
        '{1, REG_PHASE_SPEED, 16'h8000, 0, 0, 0, 0, 0},
        '{1, REG_DISTANCE_START, 16'd127, 0, 0, 0, 0, 0},
        '{1, REG_DISTANCE_END, 16'd0, 0, 0, 0, 0, 0},
        '{1, REG_ALPHA_PAIR, 16'h00FF, 0, 0, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 0, 0, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 0, 0, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 1, 0, 0, 0, 0},
        '{1, REG_POINT_COUNT, 16'd0, 0, 0, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 1, 0, 0, 0, 0},
        '{1, REG_POINT_COUNT, 16'd3, 0, 0, 0, 0, 0},
        '{1, REG_PHASE_SPEED, 16'h7FFF, 0, 0, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 1, 0, 0, 0, 0},
        '{0, REG_POINT_COUNT, 0, 0, 0, 0, 0, 0}
    };

    always @(posedge clk)
    begin
        if (hold_go && !hold_taken)
        begin
            hold_taken <= 1;
            hold_left <= 600;
            out_stall <= 1;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= recv_stall && ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t unexpected point x=%0d y=%0d", $time, offset_x, offset_y);
                errors++;
            end
            else
            begin
                e = pending_points.pop_front();
                if (offset_x !== e.x || offset_y !== e.y || blend_alpha !== e.alpha ||
                    point_index !== e.idx || last_point !== e.last)
                begin
                    $display("%0t mismatch exp x=%0d y=%0d a=%0d i=%0d l=%0d", $time,
                             e.x, e.y, e.alpha, e.idx, e.last);
                    $display("%0t          got x=%0d y=%0d a=%0d i=%0d l=%0d", $time,
                             offset_x, offset_y, blend_alpha, point_index, last_point);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= 5000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        bit prev_wr;
        point_t t;
        prev_wr = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (directed[k])
        begin
            if (directed[k].wr)
            begin
                if (!prev_wr) drain();
                write_reg(directed[k].idx, directed[k].data);
            end
            else
            begin
                if (prev_wr) cfg_valid <= 0;
                send_frame(directed[k].b);
                if (directed[k].typed)
                begin
                    void'(pending_points.pop_back());
                    t.x = 16'(directed[k].ex);
                    t.y = 16'(directed[k].ey);
                    t.alpha = 8'(directed[k].ea);
                    t.idx = 0;
                    t.last = 1;
                    pending_points.push_back(t);
                end
            end
            prev_wr = directed[k].wr;
        end
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            send_idle = (ph % 4 == 1) || (ph % 4 == 3);
            recv_stall = (ph % 4 == 2) || (ph % 4 == 3);
            idle_pct = (ph % 4 == 3) ? 19 : 59;
            write_reg(REG_POINT_COUNT, $urandom_range(9) == 0 ? 16'($urandom_range(15))
                                                               : 16'($urandom_range(1, 8)));
            write_reg(REG_BEAT_RESTART, 16'($urandom_range(3) != 0));
            write_reg(REG_ROT_STEP_START, 16'($urandom));
            write_reg(REG_ROT_STEP_END, 16'($urandom));
            write_reg(REG_ALPHA_PAIR, 16'($urandom));
            write_reg(REG_DISTANCE_START, 16'($urandom_range(127)));
            write_reg(REG_DISTANCE_END, 16'($urandom_range(127)));
            write_reg(REG_PHASE_SPEED, $urandom_range(1) ? 16'($urandom)
                                                         : 16'($urandom_range(4000)) - 16'd2000);
            cfg_valid <= 0;
            if (ph == 4) hold_go = 1;
            for (int i = 0; i < 12; i++) send_frame(1'($urandom_range(1)));
        end
        drain();
        if (errors == 0 && pending_points.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
